@@ src/irfnv_pkg.sv @@
package irfnv_pkg;

	localparam int DUR_W      = 16;
	localparam int IN_TDATA_W = ((DUR_W + 7) / 8) * 8;
	localparam int PROD_W     = DUR_W + 4;
	localparam int COUNT_W    = 8;
	localparam int HASH_W     = 32;
	localparam int CFG_W      = 8;

	localparam logic [HASH_W-1:0]  FNV_PRIME  = 32'd16777619;
	localparam logic [HASH_W-1:0]  FNV_BASIS  = 32'd2166136261;
	localparam logic [COUNT_W-1:0] COUNT_MAX  = 8'd255;
	localparam logic [COUNT_W-1:0] HASH_FROM  = 8'd3;
	localparam logic [CFG_W-1:0]   MIN_RESET  = 8'd6;

	localparam logic [1:0] CODE_SHORTER = 2'd0;
	localparam logic [1:0] CODE_SAME    = 2'd1;
	localparam logic [1:0] CODE_LONGER  = 2'd2;

	typedef struct packed {
		logic [DUR_W-1:0] duration;
		logic             last;
	} irfnv_item_t;

	// 20% tolerance: compare n*10 against o*8 both ways, full width
	function automatic logic [1:0] timing_code(input logic [DUR_W-1:0] older,
		input logic [DUR_W-1:0] newer);
		logic [PROD_W-1:0] new10;
		logic [PROD_W-1:0] old10;
		logic [PROD_W-1:0] new8;
		logic [PROD_W-1:0] old8;
		logic [1:0]        code;
		new10 = PROD_W'(newer) * PROD_W'(10);
		old10 = PROD_W'(older) * PROD_W'(10);
		new8  = PROD_W'(newer) << 3;
		old8  = PROD_W'(older) << 3;
		if (new10 < old8) begin
			code = CODE_SHORTER;
		end else if (old10 < new8) begin
			code = CODE_LONGER;
		end else begin
			code = CODE_SAME;
		end
		return code;
	endfunction

endpackage

@@ src/ir_timing_fnv_hash.sv @@
// Result path: the last beat of a frame is held in the stage-one register, then loads the
// result register (m_tvalid, m_tdata, m_tuser) when that register is free.
// Throughput: one duration beat per cycle; the hash multiply-xor feedback is the long path.
// Only the last beat of a frame waits for the result register to be free.
// Reset (arst_n low, asynchronous): buffers empty, hash back to the FNV offset basis,
// count and duration history cleared, min_samples back to 6.
module ir_timing_fnv_hash (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [irfnv_pkg::IN_TDATA_W-1:0]  s_tdata,   // duration
	input  logic                              s_tlast,   // last_of_frame
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [irfnv_pkg::HASH_W-1:0]      m_tdata,   // hash
	output logic                              m_tuser,   // valid_res
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [irfnv_pkg::CFG_W-1:0]       cfg_data   // min_samples
);

	logic                          valid_s1;
	irfnv_pkg::irfnv_item_t        item_s1;
	logic                          take;
	logic [irfnv_pkg::CFG_W-1:0]   min_samples_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_samples_q <= irfnv_pkg::MIN_RESET;
		end else if (cfg_valid && cfg_ready) begin
			min_samples_q <= cfg_data;
		end
	end

	irfnv_in_reg u_in_reg (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.take     (take),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	irfnv_core u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.valid_s1    (valid_s1),
		.item_s1     (item_s1),
		.min_samples (min_samples_q),
		.take        (take),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.m_tuser     (m_tuser)
	);

`ifndef SYNTH
	a_result_from_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !$past(m_tvalid) |-> $past(take && item_s1.last))
		else $error("result beat without a consumed last beat");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		take && item_s1.last |-> !(m_tvalid && !m_tready))
		else $error("last beat consumed while result stalled");

	a_hold_when_stuck: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !take |-> !s_tready)
		else $error("input accepted while stage one is held");
`endif

endmodule

@@ src/irfnv_in_reg.sv @@
module irfnv_in_reg (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [irfnv_pkg::IN_TDATA_W-1:0]    s_tdata,   // duration
	input  logic                                s_tlast,   // last_of_frame
	input  logic                                take,
	output logic                                valid_s1,
	output irfnv_pkg::irfnv_item_t              item_s1
);

	logic accept;

	assign s_tready = !valid_s1 || take;
	assign accept   = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (take) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1.duration <= s_tdata[irfnv_pkg::DUR_W-1:0];
			item_s1.last     <= s_tlast;
		end
	end

endmodule

@@ src/irfnv_core.sv @@
module irfnv_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          valid_s1,
	input  irfnv_pkg::irfnv_item_t        item_s1,
	input  logic [irfnv_pkg::CFG_W-1:0]   min_samples,
	output logic                          take,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [irfnv_pkg::HASH_W-1:0]  m_tdata,   // hash
	output logic                          m_tuser    // valid_res
);

	logic [irfnv_pkg::DUR_W-1:0]   prev0_q;
	logic [irfnv_pkg::DUR_W-1:0]   prev1_q;
	logic [irfnv_pkg::COUNT_W-1:0] count_q;
	logic [irfnv_pkg::HASH_W-1:0]  hash_q;

	logic                          out_free;
	logic [1:0]                    code;
	logic [irfnv_pkg::HASH_W-1:0]  hash_mul;
	logic [irfnv_pkg::HASH_W-1:0]  hash_next;
	logic [irfnv_pkg::COUNT_W-1:0] entries;

	// a last beat needs the result register; other beats never stall
	assign out_free = !m_tvalid || m_tready;
	assign take     = valid_s1 && (!item_s1.last || out_free);

	assign code      = irfnv_pkg::timing_code(prev1_q, item_s1.duration);
	assign hash_mul  = hash_q * irfnv_pkg::FNV_PRIME;
	assign hash_next = (count_q >= irfnv_pkg::HASH_FROM) ?
		(hash_mul ^ irfnv_pkg::HASH_W'(code)) : hash_q;
	assign entries   = (count_q == irfnv_pkg::COUNT_MAX) ? count_q : count_q + 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev0_q <= '0;
			prev1_q <= '0;
			count_q <= '0;
			hash_q  <= irfnv_pkg::FNV_BASIS;
		end else if (take) begin
			if (item_s1.last) begin
				prev0_q <= '0;
				prev1_q <= '0;
				count_q <= '0;
				hash_q  <= irfnv_pkg::FNV_BASIS;
			end else begin
				prev0_q <= item_s1.duration;
				prev1_q <= prev0_q;
				count_q <= entries;
				hash_q  <= hash_next;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (take && item_s1.last) begin
			m_tvalid <= 1'b1;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take && item_s1.last) begin
			m_tdata <= hash_next;
			m_tuser <= (entries >= min_samples);
		end
	end

endmodule
